/* sv/smleq_pkg.sv */
// Shared types and codes for the sequenced multi-lane event queue.
// Holds the request codes, the memory control group and the result record.
// Used by every module of the block; depends on nothing.
package smleq_pkg;

	typedef enum logic [1:0] {
		REQ_ENQUEUE = 2'd0,
		REQ_DRAIN   = 2'd1,
		REQ_CLEAR   = 2'd2,
		REQ_UNKNOWN = 2'd3
	} req_t;

	localparam int unsigned LANE_FIELD_BITS    = 2;
	localparam int unsigned DATA_FIELD_BITS    = 64;
	localparam int unsigned SEQ_BITS           = 32;
	localparam int unsigned PENDING_FIELD_BITS = 14;
	localparam int unsigned IN_TDATA_BITS      = 72;
	localparam int unsigned OUT_TDATA_BITS     = 312;

	typedef struct packed {
		logic wr_en;
		logic rd_en;
	} mem_ctl_t;

	typedef struct packed {
		logic                          op_ok;
		logic [DATA_FIELD_BITS-1:0]    out_payload;
		logic [LANE_FIELD_BITS-1:0]    out_lane;
		logic [SEQ_BITS-1:0]           out_sequence;
		logic [PENDING_FIELD_BITS-1:0] pending_total;
		logic [SEQ_BITS-1:0]           lane_dropped_count;
		logic [SEQ_BITS-1:0]           attempted_count;
		logic [SEQ_BITS-1:0]           accepted_count;
		logic [SEQ_BITS-1:0]           drained_count;
		logic [SEQ_BITS-1:0]           gap_count;
		logic [SEQ_BITS-1:0]           last_drained_seq;
	} res_t;

endpackage

/* sv/smleq_mem.sv */
// Entry store of the event queue: payload and sequence memories of all lanes.
// One write port and one read port with registered read data.
// Depends on smleq_pkg for the memory control group.
module smleq_mem
	import smleq_pkg::*;
#(
	parameter int unsigned DEPTH        = 8192,
	parameter int unsigned AW           = 13,
	parameter int unsigned PAYLOAD_BITS = 64
) (
	input  logic                    clk,
	input  mem_ctl_t                ctl,
	input  logic [AW-1:0]           wr_addr,
	input  logic [PAYLOAD_BITS-1:0] wr_payload,
	input  logic [SEQ_BITS-1:0]     wr_seq,
	input  logic [AW-1:0]           rd_addr,
	output logic [PAYLOAD_BITS-1:0] rd_payload,
	output logic [SEQ_BITS-1:0]     rd_seq
);

	logic [PAYLOAD_BITS-1:0] payload_mem [DEPTH];
	logic [SEQ_BITS-1:0]     seq_mem [DEPTH];

	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			payload_mem[wr_addr] <= wr_payload;
			seq_mem[wr_addr]     <= wr_seq;
		end
		if (ctl.rd_en) begin
			rd_payload <= payload_mem[rd_addr];
			rd_seq     <= seq_mem[rd_addr];
		end
	end

endmodule

/* sv/smleq_ctrl.sv */
// Request sequencer of the event queue: lane pointers, fill levels, counters and head scan.
// Drives the entry store through smleq_mem and hands each result to the output register.
// Depends on smleq_pkg.
module smleq_ctrl
	import smleq_pkg::*;
#(
	parameter int unsigned LANE_DEPTH   = 2048,
	parameter int unsigned LANE_COUNT   = 4,
	parameter int unsigned PAYLOAD_BITS = 64,
	parameter int unsigned AW           = 13
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  req_t                       in_req,
	input  logic [LANE_FIELD_BITS-1:0] in_lane,
	input  logic [DATA_FIELD_BITS-1:0] in_payload,
	input  logic                       out_free,
	output logic                       res_valid,
	output res_t                       res,
	output mem_ctl_t                   mem_ctl,
	output logic [AW-1:0]              mem_wr_addr,
	output logic [PAYLOAD_BITS-1:0]    mem_wr_payload,
	output logic [SEQ_BITS-1:0]        mem_wr_seq,
	output logic [AW-1:0]              mem_rd_addr,
	input  logic [PAYLOAD_BITS-1:0]    mem_rd_payload,
	input  logic [SEQ_BITS-1:0]        mem_rd_seq
);

	localparam int unsigned LW = $clog2(LANE_COUNT);
	localparam int unsigned IW = $clog2(LANE_DEPTH);
	localparam int unsigned FW = $clog2(LANE_DEPTH + 1);
	localparam int unsigned TW = $clog2(LANE_COUNT * LANE_DEPTH + 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_SCAN,
		ST_PICK,
		ST_COMMIT
	} state_t;

	state_t                  state_q;
	req_t                    req_q;
	logic [LW-1:0]           lane_q;
	logic [PAYLOAD_BITS-1:0] pay_q;

	logic [IW-1:0] wr_idx_q [LANE_COUNT];
	logic [IW-1:0] rd_idx_q [LANE_COUNT];
	logic [FW-1:0] fill_q [LANE_COUNT];
	logic [SEQ_BITS-1:0] drops_q [LANE_COUNT];

	logic [SEQ_BITS-1:0] seq_q, att_q, acc_q, drn_q, gap_q, last_q;
	logic [TW-1:0]       total_q;

	logic [LW-1:0]           scan_q;
	logic                    cmp_vld_s1;
	logic                    found_q;
	logic [LW-1:0]           best_lane_q;
	logic [SEQ_BITS-1:0]     best_seq_q;
	logic [PAYLOAD_BITS-1:0] best_pay_q;

	logic [LW-1:0]       lane_pick;
	logic [LW-1:0]       cur_lane;
	logic [FW-1:0]       cur_fill;
	logic [IW-1:0]       cur_rd;
	logic [AW-1:0]       lane_base;
	logic                full;
	logic                enq_commit, drn_commit, clr_commit, commit;
	logic                take_best;
	logic [SEQ_BITS-1:0] seq_n, att_n, acc_n, drn_n, gap_n, last_n, drops_n;
	logic [TW-1:0]       total_n;

	assign lane_pick = (32'(in_lane) < LANE_COUNT) ? LW'(in_lane) : LW'(LANE_COUNT - 1);
	assign in_ready  = (state_q == ST_IDLE);

	always_comb begin
		if (state_q == ST_SCAN) begin
			cur_lane = scan_q;
		end else if (state_q == ST_COMMIT) begin
			cur_lane = best_lane_q;
		end else begin
			cur_lane = lane_q;
		end
	end

	assign cur_fill  = fill_q[cur_lane];
	assign cur_rd    = rd_idx_q[cur_lane];
	assign lane_base = AW'(AW'(cur_lane) * AW'(LANE_DEPTH));
	assign full      = (cur_fill == FW'(LANE_DEPTH));

	assign commit     = out_free && (state_q == ST_EXEC || state_q == ST_COMMIT);
	assign enq_commit = commit && state_q == ST_EXEC && req_q == REQ_ENQUEUE;
	assign clr_commit = commit && state_q == ST_EXEC && req_q == REQ_CLEAR;
	assign drn_commit = commit && state_q == ST_COMMIT && found_q;
	assign res_valid  = commit;

	assign take_best = cmp_vld_s1 && (!found_q || mem_rd_seq < best_seq_q);

	assign mem_ctl.wr_en  = enq_commit && !full;
	assign mem_ctl.rd_en  = (state_q == ST_SCAN);
	assign mem_wr_addr    = lane_base + AW'(wr_idx_q[lane_q]);
	assign mem_rd_addr    = lane_base + AW'(cur_rd);
	assign mem_wr_payload = pay_q;
	assign mem_wr_seq     = seq_n;

	always_comb begin
		seq_n   = seq_q;
		att_n   = att_q;
		acc_n   = acc_q;
		drn_n   = drn_q;
		gap_n   = gap_q;
		last_n  = last_q;
		drops_n = drops_q[lane_q];
		total_n = total_q;
		res     = '0;
		if (enq_commit) begin
			seq_n = seq_q + 1'b1;
			att_n = att_q + 1'b1;
			if (full) begin
				gap_n   = gap_q + 1'b1;
				drops_n = drops_q[lane_q] + 1'b1;
			end else begin
				acc_n   = acc_q + 1'b1;
				total_n = total_q + 1'b1;
			end
			res.op_ok        = !full;
			res.out_lane     = LANE_FIELD_BITS'(lane_q);
			res.out_sequence = seq_n;
		end else if (clr_commit) begin
			seq_n   = '0;
			att_n   = '0;
			acc_n   = '0;
			drn_n   = '0;
			gap_n   = '0;
			last_n  = '0;
			drops_n = '0;
			total_n = '0;
		end else if (drn_commit) begin
			drn_n            = drn_q + 1'b1;
			last_n           = best_seq_q;
			total_n          = total_q - 1'b1;
			res.op_ok        = 1'b1;
			res.out_payload  = DATA_FIELD_BITS'(best_pay_q);
			res.out_lane     = LANE_FIELD_BITS'(best_lane_q);
			res.out_sequence = best_seq_q;
		end
		res.pending_total      = PENDING_FIELD_BITS'(total_n);
		res.lane_dropped_count = drops_n;
		res.attempted_count    = att_n;
		res.accepted_count     = acc_n;
		res.drained_count      = drn_n;
		res.gap_count          = gap_n;
		res.last_drained_seq   = last_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			req_q      <= REQ_ENQUEUE;
			lane_q     <= '0;
			seq_q      <= '0;
			att_q      <= '0;
			acc_q      <= '0;
			drn_q      <= '0;
			gap_q      <= '0;
			last_q     <= '0;
			total_q    <= '0;
			scan_q     <= '0;
			cmp_vld_s1 <= 1'b0;
			found_q    <= 1'b0;
			best_lane_q <= '0;
			for (int i = 0; i < LANE_COUNT; i++) begin
				wr_idx_q[i] <= '0;
				rd_idx_q[i] <= '0;
				fill_q[i]   <= '0;
				drops_q[i]  <= '0;
			end
		end else begin
			seq_q   <= seq_n;
			att_q   <= att_n;
			acc_q   <= acc_n;
			drn_q   <= drn_n;
			gap_q   <= gap_n;
			last_q  <= last_n;
			total_q <= total_n;
			if (clr_commit) begin
				for (int i = 0; i < LANE_COUNT; i++) begin
					wr_idx_q[i] <= '0;
					rd_idx_q[i] <= '0;
					fill_q[i]   <= '0;
					drops_q[i]  <= '0;
				end
			end else begin
				drops_q[lane_q] <= drops_n;
			end
			if (enq_commit && !full) begin
				wr_idx_q[lane_q] <= (wr_idx_q[lane_q] == IW'(LANE_DEPTH - 1)) ?
					'0 : wr_idx_q[lane_q] + 1'b1;
				fill_q[lane_q] <= fill_q[lane_q] + 1'b1;
			end
			if (drn_commit) begin
				rd_idx_q[best_lane_q] <= (cur_rd == IW'(LANE_DEPTH - 1)) ? '0 : cur_rd + 1'b1;
				fill_q[best_lane_q]   <= cur_fill - 1'b1;
			end
			cmp_vld_s1 <= (state_q == ST_SCAN) && (cur_fill != '0);
			if (take_best) begin
				found_q     <= 1'b1;
				best_lane_q <= scan_q - 1'b1;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						req_q   <= in_req;
						lane_q  <= lane_pick;
						scan_q  <= '0;
						found_q <= 1'b0;
						state_q <= (in_req == REQ_DRAIN) ? ST_SCAN : ST_EXEC;
					end
				end
				ST_EXEC: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				ST_SCAN: begin
					scan_q <= scan_q + 1'b1;
					if (scan_q == LW'(LANE_COUNT - 1)) begin
						state_q <= ST_PICK;
					end
				end
				ST_PICK: begin
					state_q <= ST_COMMIT;
				end
				ST_COMMIT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) begin
			pay_q <= PAYLOAD_BITS'(in_payload);
		end
		if (take_best) begin
			best_seq_q <= mem_rd_seq;
			best_pay_q <= mem_rd_payload;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		!(mem_ctl.wr_en && mem_ctl.rd_en))
		else $error("Entry store written and read in the same cycle.");

	assert property (@(posedge clk) disable iff (!arst_n)
		total_q <= TW'(LANE_COUNT * LANE_DEPTH))
		else $error("Pending total exceeds the capacity of all lanes.");

	assert property (@(posedge clk) disable iff (!arst_n)
		clr_commit |=> (att_q == '0 && seq_q == '0 && total_q == '0))
		else $error("Clear left counters or pending items behind.");

	assert property (@(posedge clk) disable iff (!arst_n)
		enq_commit |=> (att_q == $past(att_q) + 1'b1 && seq_q == $past(seq_q) + 1'b1))
		else $error("Enqueue did not advance the attempt and sequence counters.");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_COMMIT && found_q) |-> (cur_fill != '0))
		else $error("Drain picked an empty lane.");

endmodule

/* sv/sequenced_multi_lane_event_queue_unit.sv */
// Sequenced multi-lane event queue: four FIFO lanes in one entry store, merged by sequence.
// Enqueue, clear and unknown requests go through the execute state to the output register.
// A drain scans the lane heads through the single store read port, then picks and commits.
// One request is worked on at a time; the next is taken as soon as the last one is handed
// to the output register, so a waiting result does not block taking a new request, though it holds back the new result.
// Reset is asynchronous and clears pointers, fill levels and counters; the store is not cleared.
module sequenced_multi_lane_event_queue_unit
	import smleq_pkg::*;
#(
	parameter int unsigned LANE_DEPTH   = 2048,
	parameter int unsigned LANE_COUNT   = 4,
	parameter int unsigned PAYLOAD_BITS = 64
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	// Fields from bit 0: lane_select[1:0], item_payload[65:2], zero fill.
	input  logic [IN_TDATA_BITS-1:0]  s_tdata,
	// Fields from bit 0: req_type[1:0].
	input  logic [1:0]                s_tuser,
	output logic                      m_tvalid,
	input  logic                      m_tready,
	// Fields from bit 0: op_ok, out_payload, out_lane, out_sequence, pending_total,
	// lane_dropped_count, attempted_count, accepted_count, drained_count, gap_count,
	// last_drained_seq, zero fill.
	output logic [OUT_TDATA_BITS-1:0] m_tdata
);

	localparam int unsigned DEPTH = LANE_COUNT * LANE_DEPTH;
	localparam int unsigned AW    = $clog2(DEPTH);

	mem_ctl_t                mem_ctl;
	logic [AW-1:0]           mem_wr_addr, mem_rd_addr;
	logic [PAYLOAD_BITS-1:0] mem_wr_payload, mem_rd_payload;
	logic [SEQ_BITS-1:0]     mem_wr_seq, mem_rd_seq;
	logic                    res_valid;
	res_t                    res;
	res_t                    res_q;
	logic                    m_tvalid_q;
	logic                    out_free;

	assign out_free = !m_tvalid_q || m_tready;

	smleq_ctrl #(
		.LANE_DEPTH  (LANE_DEPTH),
		.LANE_COUNT  (LANE_COUNT),
		.PAYLOAD_BITS(PAYLOAD_BITS),
		.AW          (AW)
	) u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (s_tvalid),
		.in_ready      (s_tready),
		.in_req        (req_t'(s_tuser)),
		.in_lane       (s_tdata[1:0]),
		.in_payload    (s_tdata[65:2]),
		.out_free      (out_free),
		.res_valid     (res_valid),
		.res           (res),
		.mem_ctl       (mem_ctl),
		.mem_wr_addr   (mem_wr_addr),
		.mem_wr_payload(mem_wr_payload),
		.mem_wr_seq    (mem_wr_seq),
		.mem_rd_addr   (mem_rd_addr),
		.mem_rd_payload(mem_rd_payload),
		.mem_rd_seq    (mem_rd_seq)
	);

	smleq_mem #(
		.DEPTH       (DEPTH),
		.AW          (AW),
		.PAYLOAD_BITS(PAYLOAD_BITS)
	) u_mem (
		.clk       (clk),
		.ctl       (mem_ctl),
		.wr_addr   (mem_wr_addr),
		.wr_payload(mem_wr_payload),
		.wr_seq    (mem_wr_seq),
		.rd_addr   (mem_rd_addr),
		.rd_payload(mem_rd_payload),
		.rd_seq    (mem_rd_seq)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (res_valid) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			res_q <= res;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {
		7'd0,
		res_q.last_drained_seq,
		res_q.gap_count,
		res_q.drained_count,
		res_q.accepted_count,
		res_q.attempted_count,
		res_q.lane_dropped_count,
		res_q.pending_total,
		res_q.out_sequence,
		res_q.out_lane,
		res_q.out_payload,
		res_q.op_ok
	};

endmodule
